// File: design/vss_pkg.sv
// Package for the visual servo setpoint step block.
// Holds the shared widths, register indexes, reset values, the sequencer state type
// and the divider request type. It depends on nothing else.
`default_nettype none

package vss_pkg;

  localparam int POS_W      = 32;
  localparam int PIX_W      = 16;
  localparam int MUL_W      = 34;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int DIV_NUM_W  = 64;
  localparam int DIV_DEN_W  = 33;
  localparam int DIV_CNT_W  = $clog2(DIV_NUM_W);
  localparam int ROOT_W     = 33;
  localparam int ACC_W      = 2 * ROOT_W;
  localparam int SQ_CNT_W   = $clog2(ROOT_W);
  localparam int SQ_REM_W   = ROOT_W + 2;
  localparam int SAT_W      = PROD_W + 1;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_CENTER_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_CENTER_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REFERENCE_AREA    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LATERAL_GAIN      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_GAIN        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_LENGTH       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_ARRIVAL_TOLERANCE = 3'd6;

  localparam logic [15:0] RST_IMAGE_CENTER_X    = 16'd375;
  localparam logic [15:0] RST_IMAGE_CENTER_Y    = 16'd240;
  localparam logic [31:0] RST_REFERENCE_AREA    = 32'd8000;
  localparam logic [23:0] RST_LATERAL_GAIN      = 24'd3277;
  localparam logic [23:0] RST_DEPTH_GAIN        = 24'd65536;
  localparam logic [30:0] RST_STEP_LENGTH       = 31'd65536;
  localparam logic [30:0] RST_ARRIVAL_TOLERANCE = 31'd13107;

  localparam logic REQ_POSITION = 1'b0;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_OX,
    ST_OY,
    ST_AREA,
    ST_DIFF,
    ST_OZ_MUL,
    ST_OZ_DIV,
    ST_OZ_WAIT,
    ST_DZ,
    ST_SQ_Y,
    ST_SQ_Z,
    ST_TOL,
    ST_STEP,
    ST_CMP,
    ST_ROOT,
    ST_AX_MUL,
    ST_AX_DIV,
    ST_AX_WAIT,
    ST_DONE
  } vss_state_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } vss_div_req_t;

endpackage

`default_nettype wire

// File: design/vss_mul.sv
// Shared signed multiplier with a registered product.
// Depends on vss_pkg for the operand width.
`default_nettype none

module vss_mul (
  input  wire                                 clk,
  input  wire logic signed [vss_pkg::MUL_W-1:0]  a,
  input  wire logic signed [vss_pkg::MUL_W-1:0]  b,
  output logic signed [vss_pkg::PROD_W-1:0]      p
);
  import vss_pkg::*;

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

`default_nettype wire

// File: design/vss_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on vss_pkg for its widths and the request type.
`default_nettype none

module vss_div (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire vss_pkg::vss_div_req_t           req,
  output logic                                 busy,
  output logic                                 done,
  output logic [vss_pkg::DIV_NUM_W-1:0]        quo
);
  import vss_pkg::*;

  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_DEN_W-1:0] den;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_DEN_W:0]   rem_sh;
  logic                 fits;

  assign rem_sh = {rem, quo[DIV_NUM_W-1]};
  assign fits   = rem_sh >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(DIV_NUM_W - 1);
        rem  <= '0;
        quo  <= req.num;
        den  <= req.den;
      end else if (busy) begin
        rem <= fits ? DIV_DEN_W'(rem_sh - {1'b0, den}) : rem_sh[DIV_DEN_W-1:0];
        quo <= {quo[DIV_NUM_W-2:0], fits};
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: design/vss_sqrt.sv
// Digit-by-digit floor square root, one root bit per cycle.
// Depends on vss_pkg for its widths.
`default_nettype none

module vss_sqrt (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               start,
  input  wire [vss_pkg::ACC_W-1:0]          rad,
  output logic                              busy,
  output logic                              done,
  output logic [vss_pkg::ROOT_W-1:0]        root
);
  import vss_pkg::*;

  logic [ACC_W-1:0]    shreg;
  logic [SQ_REM_W-1:0] rem;
  logic [SQ_CNT_W-1:0] cnt;
  logic [SQ_REM_W+1:0] rem_sh;
  logic [SQ_REM_W+1:0] trial;
  logic                fits;

  assign rem_sh = {rem, shreg[ACC_W-1:ACC_W-2]};
  assign trial  = {2'b00, root, 2'b01};
  assign fits   = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= SQ_CNT_W'(ROOT_W - 1);
        rem   <= '0;
        root  <= '0;
        shreg <= rad;
      end else if (busy) begin
        rem   <= fits ? SQ_REM_W'(rem_sh - trial) : rem_sh[SQ_REM_W-1:0];
        root  <= {root[ROOT_W-2:0], fits};
        shreg <= {shreg[ACC_W-3:0], 2'b00};
        cnt   <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: design/visual_servo_setpoint_step_top.sv
// Top level of the visual servo setpoint step block: sequencer, registers and datapath.
// Depends on vss_pkg and instantiates vss_mul, vss_div and vss_sqrt.
//
// Usage. The input channel (in_valid, in_ready) carries one word per item. A word with
// req_type low is a position fix: it is stored as the held position in the cycle it is
// accepted and gives no result. A word with req_type high is a box detection and gives
// exactly one result word on the output channel (out_valid, out_ready).
// A box skips the square root and the per-axis divisions when the target is within
// tolerance, closer than one step or the step length is zero; when the setpoint is stepped
// along the direction to the target they run too. The work shares the one multiplier,
// the one-bit-per-cycle divider (used for the depth offset and once per axis) and the
// one-bit-per-cycle square root. in_ready is high only while the sequencer is idle.
// The result sits in an output register; while it waits, new words are still taken, and
// a later box waits at its end until the output register is free.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) is always ready
// and is meant to be written while the block is idle; unknown indexes are ignored.
// Synchronous reset restores the register defaults, clears the held position and drops
// any pending result.
`default_nettype none

module visual_servo_setpoint_step_top (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   in_valid,
  output logic                                  in_ready,
  input  wire                                   req_type,
  input  wire logic signed [vss_pkg::POS_W-1:0] new_x,
  input  wire logic signed [vss_pkg::POS_W-1:0] new_y,
  input  wire logic signed [vss_pkg::POS_W-1:0] new_z,
  input  wire [vss_pkg::PIX_W-1:0]              box_x,
  input  wire [vss_pkg::PIX_W-1:0]              box_y,
  input  wire [vss_pkg::PIX_W-1:0]              box_w,
  input  wire [vss_pkg::PIX_W-1:0]              box_h,
  output logic                                  out_valid,
  input  wire                                   out_ready,
  output logic                                  arrived,
  output logic signed [vss_pkg::POS_W-1:0]      setpoint_x,
  output logic signed [vss_pkg::POS_W-1:0]      setpoint_y,
  output logic signed [vss_pkg::POS_W-1:0]      setpoint_z,
  input  wire                                   cfg_valid,
  output logic                                  cfg_ready,
  input  wire [vss_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  wire [vss_pkg::CFG_DATA_W-1:0]         cfg_data
);
  import vss_pkg::*;

  function automatic logic signed [POS_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
    logic same;
    same = (&v[SAT_W-1:POS_W-1]) | ~(|v[SAT_W-1:POS_W-1]);
    if (same) begin
      return v[POS_W-1:0];
    end
    return v[SAT_W-1] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
  endfunction

  vss_state_t state;
  vss_state_t state_next;

  logic [15:0] center_x;
  logic [15:0] center_y;
  logic [31:0] ref_area;
  logic [23:0] lat_gain;
  logic [23:0] dep_gain;
  logic [30:0] step_len;
  logic [30:0] tolerance;

  logic signed [POS_W-1:0] held_x;
  logic signed [POS_W-1:0] held_y;
  logic signed [POS_W-1:0] held_z;

  logic [PIX_W-1:0] bx;
  logic [PIX_W-1:0] by;
  logic [PIX_W-1:0] bw;
  logic [PIX_W-1:0] bh;

  logic signed [POS_W-1:0] tx;
  logic signed [POS_W-1:0] ty;
  logic signed [POS_W-1:0] tz;
  logic signed [POS_W:0]   dx;
  logic signed [POS_W:0]   dy;
  logic signed [POS_W:0]   dz;
  logic signed [32:0]      diff;
  logic [ACC_W-1:0]        acc;
  logic                    within_tol;
  logic [DIV_DEN_W-1:0]    distance;
  logic                    neg;
  logic [1:0]              axis;

  logic                    res_arrived;
  logic signed [POS_W-1:0] sp_x;
  logic signed [POS_W-1:0] sp_y;
  logic signed [POS_W-1:0] sp_z;

  logic signed [MUL_W-1:0]  mul_a;
  logic signed [MUL_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] p;
  logic [PROD_W-1:0]        p_abs;

  vss_div_req_t         div_req;
  logic                 div_busy;
  logic                 div_done;
  logic [DIV_NUM_W-1:0] quo;

  logic                 sqrt_start;
  logic                 sqrt_busy;
  logic                 sqrt_done;
  logic [ROOT_W-1:0]    root;

  logic [31:0]             refe;
  logic [PIX_W:0]          cx;
  logic [PIX_W:0]          cy;
  logic signed [PIX_W+1:0] off_x;
  logic signed [PIX_W+1:0] off_y;
  logic                    lt_step;
  logic                    out_free;
  logic signed [POS_W-1:0] base;
  logic signed [POS_W:0]   d_sel;
  logic signed [SAT_W-1:0] base_ext;
  logic signed [SAT_W-1:0] p_sum;
  logic signed [SAT_W-1:0] q_mag;
  logic signed [SAT_W-1:0] q_sum;

  vss_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (p)
  );

  vss_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .busy (div_busy),
    .done (div_done),
    .quo  (quo)
  );

  vss_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sqrt_start),
    .rad   (acc),
    .busy  (sqrt_busy),
    .done  (sqrt_done),
    .root  (root)
  );

  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;

  assign refe    = (ref_area == '0) ? 32'd1 : ref_area;
  assign cx      = {1'b0, bx} + {2'b00, bw[PIX_W-1:1]};
  assign cy      = {1'b0, by} + {2'b00, bh[PIX_W-1:1]};
  assign off_x   = $signed({1'b0, cx}) - $signed({2'b00, center_x});
  assign off_y   = $signed({1'b0, cy}) - $signed({2'b00, center_y});
  assign p_abs   = p[PROD_W-1] ? PROD_W'(-p) : p;
  assign lt_step = acc < p[ACC_W-1:0];

  always_comb begin
    case (axis)
      2'd0:    d_sel = dx;
      2'd1:    d_sel = dy;
      default: d_sel = dz;
    endcase
    case (state)
      ST_OY:      base = held_x;
      ST_AREA:    base = held_y;
      ST_OZ_WAIT: base = held_z;
      default: begin
        case (axis)
          2'd0:    base = held_x;
          2'd1:    base = held_y;
          default: base = held_z;
        endcase
      end
    endcase
    base_ext = {{(SAT_W-POS_W){base[POS_W-1]}}, base};
    p_sum    = base_ext + $signed({p[PROD_W-1], p});
    q_mag    = $signed({{(SAT_W-DIV_NUM_W){1'b0}}, quo});
    q_sum    = neg ? (base_ext - q_mag) : (base_ext + q_mag);
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid && req_type != REQ_POSITION) begin
          state_next = ST_OX;
        end
      end
      ST_OX:      state_next = ST_OY;
      ST_OY:      state_next = ST_AREA;
      ST_AREA:    state_next = ST_DIFF;
      ST_DIFF:    state_next = ST_OZ_MUL;
      ST_OZ_MUL:  state_next = ST_OZ_DIV;
      ST_OZ_DIV:  state_next = ST_OZ_WAIT;
      ST_OZ_WAIT: begin
        if (div_done) begin
          state_next = ST_DZ;
        end
      end
      ST_DZ:      state_next = ST_SQ_Y;
      ST_SQ_Y:    state_next = ST_SQ_Z;
      ST_SQ_Z:    state_next = ST_TOL;
      ST_TOL:     state_next = ST_STEP;
      ST_STEP:    state_next = ST_CMP;
      ST_CMP: begin
        if (within_tol || lt_step || step_len == '0) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (sqrt_done) begin
          state_next = ST_AX_MUL;
        end
      end
      ST_AX_MUL:  state_next = ST_AX_DIV;
      ST_AX_DIV:  state_next = ST_AX_WAIT;
      ST_AX_WAIT: begin
        if (div_done) begin
          state_next = (axis == 2'd2) ? ST_DONE : ST_AX_MUL;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    mul_a         = '0;
    mul_b         = '0;
    div_req.start = (state == ST_OZ_DIV) || (state == ST_AX_DIV);
    div_req.num   = p_abs[DIV_NUM_W-1:0];
    div_req.den   = (state == ST_OZ_DIV) ? {1'b0, refe} : distance;
    sqrt_start    = (state == ST_CMP) && !within_tol && !lt_step && (step_len != '0);
    case (state)
      ST_OX: begin
        mul_a = {{(MUL_W-PIX_W-2){off_x[PIX_W+1]}}, off_x};
        mul_b = {{(MUL_W-24){1'b0}}, lat_gain};
      end
      ST_OY: begin
        mul_a = {{(MUL_W-PIX_W-2){off_y[PIX_W+1]}}, off_y};
        mul_b = {{(MUL_W-24){1'b0}}, lat_gain};
      end
      ST_AREA: begin
        mul_a = {{(MUL_W-PIX_W){1'b0}}, bw};
        mul_b = {{(MUL_W-PIX_W){1'b0}}, bh};
      end
      ST_OZ_MUL: begin
        mul_a = {{(MUL_W-33){diff[32]}}, diff};
        mul_b = {{(MUL_W-24){1'b0}}, dep_gain};
      end
      ST_DZ: begin
        mul_a = {{(MUL_W-POS_W-1){dx[POS_W]}}, dx};
        mul_b = {{(MUL_W-POS_W-1){dx[POS_W]}}, dx};
      end
      ST_SQ_Y: begin
        mul_a = {{(MUL_W-POS_W-1){dy[POS_W]}}, dy};
        mul_b = {{(MUL_W-POS_W-1){dy[POS_W]}}, dy};
      end
      ST_SQ_Z: begin
        mul_a = {{(MUL_W-POS_W-1){dz[POS_W]}}, dz};
        mul_b = {{(MUL_W-POS_W-1){dz[POS_W]}}, dz};
      end
      ST_TOL: begin
        mul_a = {{(MUL_W-31){1'b0}}, tolerance};
        mul_b = {{(MUL_W-31){1'b0}}, tolerance};
      end
      ST_STEP: begin
        mul_a = {{(MUL_W-31){1'b0}}, step_len};
        mul_b = {{(MUL_W-31){1'b0}}, step_len};
      end
      ST_AX_MUL: begin
        mul_a = {{(MUL_W-POS_W-1){d_sel[POS_W]}}, d_sel};
        mul_b = {{(MUL_W-31){1'b0}}, step_len};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      held_x    <= '0;
      held_y    <= '0;
      held_z    <= '0;
      center_x  <= RST_IMAGE_CENTER_X;
      center_y  <= RST_IMAGE_CENTER_Y;
      ref_area  <= RST_REFERENCE_AREA;
      lat_gain  <= RST_LATERAL_GAIN;
      dep_gain  <= RST_DEPTH_GAIN;
      step_len  <= RST_STEP_LENGTH;
      tolerance <= RST_ARRIVAL_TOLERANCE;
      axis      <= '0;
    end else begin
      state <= state_next;
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid) begin
        case (cfg_index)
          CFG_IMAGE_CENTER_X:    center_x  <= cfg_data[15:0];
          CFG_IMAGE_CENTER_Y:    center_y  <= cfg_data[15:0];
          CFG_REFERENCE_AREA:    ref_area  <= cfg_data;
          CFG_LATERAL_GAIN:      lat_gain  <= cfg_data[23:0];
          CFG_DEPTH_GAIN:        dep_gain  <= cfg_data[23:0];
          CFG_STEP_LENGTH:       step_len  <= cfg_data[30:0];
          CFG_ARRIVAL_TOLERANCE: tolerance <= cfg_data[30:0];
          default: begin
          end
        endcase
      end
      case (state)
        ST_IDLE: begin
          if (in_valid && req_type == REQ_POSITION) begin
            held_x <= new_x;
            held_y <= new_y;
            held_z <= new_z;
          end
        end
        ST_ROOT: begin
          axis <= '0;
        end
        ST_AX_WAIT: begin
          if (div_done) begin
            axis <= axis + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        bx <= box_x;
        by <= box_y;
        bw <= box_w;
        bh <= box_h;
      end
      ST_OY: begin
        tx <= sat32(p_sum);
      end
      ST_AREA: begin
        ty <= sat32(p_sum);
        dx <= $signed({tx[POS_W-1], tx}) - $signed({held_x[POS_W-1], held_x});
      end
      ST_DIFF: begin
        diff <= $signed({1'b0, p[31:0]}) - $signed({1'b0, refe});
        dy   <= $signed({ty[POS_W-1], ty}) - $signed({held_y[POS_W-1], held_y});
      end
      ST_OZ_DIV: begin
        neg <= p[PROD_W-1];
      end
      ST_OZ_WAIT: begin
        if (div_done) begin
          tz <= sat32(q_sum);
        end
      end
      ST_DZ: begin
        dz <= $signed({tz[POS_W-1], tz}) - $signed({held_z[POS_W-1], held_z});
      end
      ST_SQ_Y: begin
        acc <= p[ACC_W-1:0];
      end
      ST_SQ_Z: begin
        acc <= acc + p[ACC_W-1:0];
      end
      ST_TOL: begin
        acc <= acc + p[ACC_W-1:0];
      end
      ST_STEP: begin
        within_tol <= acc < p[ACC_W-1:0];
      end
      ST_CMP: begin
        res_arrived <= within_tol;
        if (!within_tol && lt_step) begin
          sp_x <= tx;
          sp_y <= ty;
          sp_z <= tz;
        end else begin
          sp_x <= held_x;
          sp_y <= held_y;
          sp_z <= held_z;
        end
      end
      ST_ROOT: begin
        distance <= (root == '0) ? DIV_DEN_W'(1) : DIV_DEN_W'(root);
      end
      ST_AX_DIV: begin
        neg <= p[PROD_W-1];
      end
      ST_AX_WAIT: begin
        if (div_done) begin
          case (axis)
            2'd0:    sp_x <= sat32(q_sum);
            2'd1:    sp_y <= sat32(q_sum);
            default: sp_z <= sat32(q_sum);
          endcase
        end
      end
      ST_DONE: begin
        if (out_free) begin
          arrived    <= res_arrived;
          setpoint_x <= sp_x;
          setpoint_y <= sp_y;
          setpoint_z <= sp_z;
        end
      end
      default: begin
      end
    endcase
  end

  a_div_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_OZ_WAIT || state == ST_AX_WAIT))
    else $error("divider finished outside a wait state");

  a_sqrt_start_idle: assert property (@(posedge clk) disable iff (rst)
    sqrt_start |-> !sqrt_busy && !div_busy)
    else $error("square root started while a unit was busy");

  a_axis_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_AX_MUL || state == ST_AX_WAIT) |-> axis != 2'd3)
    else $error("axis index out of range");

  a_position_no_work: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && req_type == REQ_POSITION) |=> state == ST_IDLE)
    else $error("position word started the sequencer");

endmodule

`default_nettype wire

// File: sim/visual_servo_setpoint_step_top_tb.sv
// Self-checking testbench for visual_servo_setpoint_step_top: position fixes and box detections
// go in, and each setpoint word is compared against an in-bench fixed-point predictor.
// Depends on vss_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module visual_servo_setpoint_step_top_tb;
  import vss_pkg::*;

  typedef struct {
    logic                    req;
    logic signed [POS_W-1:0] fx;
    logic signed [POS_W-1:0] fy;
    logic signed [POS_W-1:0] fz;
    logic [PIX_W-1:0]        bx;
    logic [PIX_W-1:0]        by;
    logic [PIX_W-1:0]        bw;
    logic [PIX_W-1:0]        bh;
  } sensor_word_t;

  typedef struct {
    logic                    arr;
    logic signed [POS_W-1:0] sx;
    logic signed [POS_W-1:0] sy;
    logic signed [POS_W-1:0] sz;
  } setpoint_t;

  typedef struct {
    logic [15:0] icx;
    logic [15:0] icy;
    logic [31:0] refa;
    logic [23:0] lat;
    logic [23:0] dg;
    logic [30:0] stp;
    logic [30:0] tol;
  } servo_cfg_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    req_type = 1'b0;
  logic signed [POS_W-1:0] new_x = '0;
  logic signed [POS_W-1:0] new_y = '0;
  logic signed [POS_W-1:0] new_z = '0;
  logic [PIX_W-1:0]        box_x = '0;
  logic [PIX_W-1:0]        box_y = '0;
  logic [PIX_W-1:0]        box_w = '0;
  logic [PIX_W-1:0]        box_h = '0;
  logic                    out_ready = 1'b0;
  logic                    cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;
  logic                    in_ready;
  logic                    out_valid;
  logic                    arrived;
  logic signed [POS_W-1:0] setpoint_x;
  logic signed [POS_W-1:0] setpoint_y;
  logic signed [POS_W-1:0] setpoint_z;
  logic                    cfg_ready;

  sensor_word_t words_to_send[$];
  setpoint_t    setpoints_due[$];
  sensor_word_t word_on_bus;

  longint ctr_x_px     = RST_IMAGE_CENTER_X;
  longint ctr_y_px     = RST_IMAGE_CENTER_Y;
  longint ref_area_px  = RST_REFERENCE_AREA;
  longint lat_gain_q   = RST_LATERAL_GAIN;
  longint depth_gain_q = RST_DEPTH_GAIN;
  longint step_q       = RST_STEP_LENGTH;
  longint tol_q        = RST_ARRIVAL_TOLERANCE;
  longint held_x = 0;
  longint held_y = 0;
  longint held_z = 0;

  int   sender_idle_pct = 0;
  int   recv_stall_pct  = 0;
  int   fail_count      = 0;
  logic hold_off        = 1'b0;
  logic squeeze_go      = 1'b0;

  visual_servo_setpoint_step_top u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .new_x      (new_x),
    .new_y      (new_y),
    .new_z      (new_z),
    .box_x      (box_x),
    .box_y      (box_y),
    .box_w      (box_w),
    .box_h      (box_h),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .arrived    (arrived),
    .setpoint_x (setpoint_x),
    .setpoint_y (setpoint_y),
    .setpoint_z (setpoint_z),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic signed [POS_W-1:0] clip_q16(input longint v);
    if (v > 64'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end
    if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic logic [127:0] square_mag(input longint v);
    logic [127:0] m;
    m = (v < 0) ? -v : v;
    return m * m;
  endfunction

  function automatic longint floor_root(input logic [127:0] v);
    logic [127:0] root;
    logic [127:0] cand;
    root = '0;
    for (int b = 34; b >= 0; b--) begin
      cand = root | (128'd1 << b);
      if (cand * cand <= v) begin
        root = cand;
      end
    end
    return longint'(root[63:0]);
  endfunction

  function automatic setpoint_t plan_setpoint(input sensor_word_t w);
    longint       cx, cy, area, refa, ox, oy, oz, tx, ty, tz, dx, dy, dz, distance;
    logic [127:0] dist_sq;
    setpoint_t    r;
    cx   = longint'(w.bx) + longint'(w.bw >> 1);
    cy   = longint'(w.by) + longint'(w.bh >> 1);
    area = longint'(w.bw) * longint'(w.bh);
    refa = (ref_area_px == 0) ? 64'sd1 : ref_area_px;
    ox   = (cx - ctr_x_px) * lat_gain_q;
    oy   = (cy - ctr_y_px) * lat_gain_q;
    oz   = ((area - refa) * depth_gain_q) / refa;
    tx   = clip_q16(held_x + ox);
    ty   = clip_q16(held_y + oy);
    tz   = clip_q16(held_z + oz);
    dx   = tx - held_x;
    dy   = ty - held_y;
    dz   = tz - held_z;
    dist_sq = square_mag(dx) + square_mag(dy) + square_mag(dz);
    r.arr = 1'b0;
    r.sx  = held_x[31:0];
    r.sy  = held_y[31:0];
    r.sz  = held_z[31:0];
    if (dist_sq < square_mag(tol_q)) begin
      r.arr = 1'b1;
    end else if (dist_sq < square_mag(step_q)) begin
      r.sx = tx[31:0];
      r.sy = ty[31:0];
      r.sz = tz[31:0];
    end else if (step_q != 0) begin
      distance = floor_root(dist_sq);
      if (distance == 0) begin
        distance = 1;
      end
      r.sx = clip_q16(held_x + (dx * step_q) / distance);
      r.sy = clip_q16(held_y + (dy * step_q) / distance);
      r.sz = clip_q16(held_z + (dz * step_q) / distance);
    end
    return r;
  endfunction

  function automatic logic [PIX_W-1:0] clamp16(input longint v);
    if (v < 0) begin
      return '0;
    end
    if (v > 65535) begin
      return 16'hFFFF;
    end
    return v[15:0];
  endfunction

  function automatic logic signed [POS_W-1:0] random_q16();
    case ($urandom_range(3))
      1: return $urandom_range(0, 20 << 16) - (10 << 16);
      2: begin
        case ($urandom_range(3))
          0: return 32'sh7FFFFFFF;
          1: return 32'sh80000000;
          2: return 32'sh0;
          default: return -32'sd1;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  function automatic sensor_word_t random_word();
    sensor_word_t w;
    longint       refa, bw, bh;
    int unsigned  pick;
    w = '{default: '0};
    pick = $urandom_range(99);
    if (pick < 35) begin
      w.req = REQ_POSITION;
      w.fx  = random_q16();
      w.fy  = random_q16();
      w.fz  = random_q16();
    end else begin
      w.req = ~REQ_POSITION;
      pick = $urandom_range(99);
      if (pick < 45) begin
        refa = (ref_area_px == 0) ? 64'sd1 : ref_area_px;
        bw   = $urandom_range(1, 255);
        bh   = refa / bw + longint'($urandom_range(0, 4)) - 2;
        w.bw = clamp16(bw);
        w.bh = clamp16(bh);
        w.bx = clamp16(ctr_x_px - (w.bw >> 1) + longint'($urandom_range(0, 12)) - 6);
        w.by = clamp16(ctr_y_px - (w.bh >> 1) + longint'($urandom_range(0, 12)) - 6);
      end else if (pick < 75) begin
        w.bw = 16'($urandom_range(0, 400));
        w.bh = 16'($urandom_range(0, 400));
        w.bx = clamp16(ctr_x_px - (w.bw >> 1) + longint'($urandom_range(0, 600)) - 300);
        w.by = clamp16(ctr_y_px - (w.bh >> 1) + longint'($urandom_range(0, 600)) - 300);
      end else if (pick < 92) begin
        w.bx = 16'($urandom_range(0, 65535));
        w.by = 16'($urandom_range(0, 65535));
        w.bw = 16'($urandom_range(0, 65535));
        w.bh = 16'($urandom_range(0, 65535));
      end else begin
        w.bx = $urandom_range(1) ? 16'hFFFF : 16'h0;
        w.by = $urandom_range(1) ? 16'hFFFF : 16'h0;
        w.bw = $urandom_range(1) ? 16'hFFFF : 16'h0;
        w.bh = $urandom_range(1) ? 16'hFFFF : 16'h0;
      end
    end
    return w;
  endfunction

  function automatic void add_fix(input logic signed [POS_W-1:0] x, y, z);
    sensor_word_t w;
    w = '{default: '0};
    w.req = REQ_POSITION;
    w.fx  = x;
    w.fy  = y;
    w.fz  = z;
    words_to_send.push_back(w);
  endfunction

  function automatic void add_box(input logic [PIX_W-1:0] bx, by, bw, bh);
    sensor_word_t w;
    w = '{default: '0};
    w.req = ~REQ_POSITION;
    w.bx  = bx;
    w.by  = by;
    w.bw  = bw;
    w.bh  = bh;
    words_to_send.push_back(w);
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_IMAGE_CENTER_X:    ctr_x_px     = data[15:0];
      CFG_IMAGE_CENTER_Y:    ctr_y_px     = data[15:0];
      CFG_REFERENCE_AREA:    ref_area_px  = data;
      CFG_LATERAL_GAIN:      lat_gain_q   = data[23:0];
      CFG_DEPTH_GAIN:        depth_gain_q = data[23:0];
      CFG_STEP_LENGTH:       step_q       = data[30:0];
      CFG_ARRIVAL_TOLERANCE: tol_q        = data[30:0];
      default: ;
    endcase
  endtask

  task automatic load_settings(input servo_cfg_t s);
    write_reg(CFG_IMAGE_CENTER_X, {16'd0, s.icx});
    write_reg(CFG_IMAGE_CENTER_Y, {16'd0, s.icy});
    write_reg(CFG_REFERENCE_AREA, s.refa);
    write_reg(CFG_LATERAL_GAIN, {8'd0, s.lat});
    write_reg(CFG_DEPTH_GAIN, {8'd0, s.dg});
    write_reg(CFG_STEP_LENGTH, {1'b0, s.stp});
    write_reg(CFG_ARRIVAL_TOLERANCE, {1'b0, s.tol});
    cfg_valid <= 1'b0;
  endtask

  // Sampling at the falling edge sees the driver and the block after their updates.
  task automatic settle();
    do @(negedge clk);
    while (words_to_send.size() != 0 || in_valid || setpoints_due.size() != 0 || !in_ready);
    repeat (20) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic signed [31:0] want, got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        if (word_on_bus.req == REQ_POSITION) begin
          held_x = word_on_bus.fx;
          held_y = word_on_bus.fy;
          held_z = word_on_bus.fz;
        end else begin
          setpoints_due.push_back(plan_setpoint(word_on_bus));
        end
      end
      if (!in_valid || in_ready) begin
        if (words_to_send.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          word_on_bus = words_to_send.pop_front();
          in_valid <= 1'b1;
          req_type <= word_on_bus.req;
          new_x    <= word_on_bus.fx;
          new_y    <= word_on_bus.fy;
          new_z    <= word_on_bus.fz;
          box_x    <= word_on_bus.bx;
          box_y    <= word_on_bus.by;
          box_w    <= word_on_bus.bw;
          box_h    <= word_on_bus.bh;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : result_monitor
    setpoint_t due;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (setpoints_due.size() == 0) begin
          $error("result word arrived with no setpoint due");
          fail_count++;
        end else begin
          due = setpoints_due.pop_front();
          check_field("arrived", {31'd0, due.arr}, {31'd0, arrived});
          check_field("setpoint_x", due.sx, setpoint_x);
          check_field("setpoint_y", due.sy, setpoint_y);
          check_field("setpoint_z", due.sz, setpoint_z);
        end
      end
      out_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // The receiver backs off for a long stretch so that a result sits in the output
  // register and the next box stalls the input channel.
  initial begin
    wait (squeeze_go);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (3000) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    servo_cfg_t cfg;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    add_box(16'd325, 16'd200, 16'd100, 16'd80);
    add_box(16'd326, 16'd200, 16'd100, 16'd80);
    add_box(16'd330, 16'd200, 16'd100, 16'd80);
    add_box(16'd400, 16'd200, 16'd100, 16'd80);
    add_box(16'd325, 16'd0, 16'd100, 16'd80);
    add_box(16'd25, 16'd40, 16'd700, 16'd400);
    add_box(16'd375, 16'd240, 16'd1, 16'd1);
    add_box(16'h0, 16'h0, 16'h0, 16'h0);
    add_box(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    add_fix(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
    add_box(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    add_box(16'd330, 16'd200, 16'd100, 16'd80);
    add_fix(32'sh80000000, 32'sh80000000, 32'sh80000000);
    add_box(16'h0, 16'h0, 16'h0, 16'h0);
    add_box(16'd325, 16'd200, 16'd100, 16'd80);
    add_fix(32'sh12345678, 32'shEDCBA988, 32'sh0);
    add_box(16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA);
    add_fix(32'sd1, -32'sd1, 32'sh55555555);
    add_box(16'd400, 16'd200, 16'd100, 16'd80);
    add_fix(32'sh0, 32'sh0, 32'sh0);
    settle();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          cfg = '{RST_IMAGE_CENTER_X, RST_IMAGE_CENTER_Y, RST_REFERENCE_AREA, RST_LATERAL_GAIN,
                  RST_DEPTH_GAIN, RST_STEP_LENGTH, RST_ARRIVAL_TOLERANCE};
          sender_idle_pct = 0;
          recv_stall_pct  = 0;
        end
        1: begin
          cfg = '{16'd0, 16'hFFFF, 32'd1, 24'hFFFFFF, 24'd0, 31'h7FFFFFFF, 31'd0};
          sender_idle_pct = 86;
          recv_stall_pct  = 0;
        end
        2: begin
          cfg = '{16'hFFFF, 16'd0, 32'd4294836225, 24'd0, 24'hFFFFFF, 31'd1, 31'd1};
          sender_idle_pct = 0;
          recv_stall_pct  = 86;
        end
        3: begin
          cfg = '{16'($urandom_range(0, 800)), 16'($urandom_range(0, 600)), 32'd0,
                  24'($urandom_range(0, 8000)), 24'($urandom_range(1, 24'hFFFFFF)), 31'd0,
                  31'($urandom_range(0, 30000))};
          sender_idle_pct = 15;
          recv_stall_pct  = 15;
        end
        default: begin
          cfg = '{16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                  32'($urandom_range(1, 32'hFFFFFFFF)), 24'($urandom_range(24'h8000, 24'hFFFFFF)),
                  24'($urandom_range(0, 24'hFFFFFF)), 31'($urandom_range(1, 31'h7FFFFFFF)),
                  31'h7FFFFFFF};
          sender_idle_pct = 15;
          recv_stall_pct  = 15;
        end
      endcase
      load_settings(cfg);
      if (ph == 0) begin
        squeeze_go = 1'b1;
      end
      if (ph == 3) begin
        add_fix(32'sh0, 32'sh0, 32'sh0);
        add_box(16'h0, 16'h0, 16'h0, 16'h0);
        add_box(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        add_box(clamp16(ctr_x_px), clamp16(ctr_y_px), 16'd1, 16'd1);
      end
      repeat (265) words_to_send.push_back(random_word());
      settle();
    end

    repeat (400) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: files.f
design/vss_pkg.sv
design/vss_mul.sv
design/vss_div.sv
design/vss_sqrt.sv
design/visual_servo_setpoint_step_top.sv
sim/visual_servo_setpoint_step_top_tb.sv
